/* src/nrsf_pkg.sv */
// ----------------------------------------------------------------------------
// nrsf_pkg
// Shared types and constants for the RMC sentence filter.
// ----------------------------------------------------------------------------
package nrsf_pkg;

   localparam int DATA_W    = 8;
   localparam int ADDR_W    = 8;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 7;
   localparam int OFF_W     = 7;
   localparam int HDR_LEN   = 6;

   localparam logic [CSR_IDX_W-1:0] REG_CAPTURE_LENGTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_VALIDITY_WINDOW = 1'd1;

   localparam logic [6:0] CAPTURE_LENGTH_RST  = 7'd40;
   localparam logic [5:0] VALIDITY_WINDOW_RST = 6'd20;

   localparam logic [DATA_W-1:0] CHAR_DOLLAR = 8'h24;
   localparam logic [DATA_W-1:0] CHAR_COMMA  = 8'h2c;
   localparam logic [DATA_W-1:0] CHAR_A      = 8'h41;

   localparam logic [OFF_W-1:0] OFF_MAX = 7'd127;

   // one write into the capture cells
   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
   } cap_wr_type;

   function automatic logic [DATA_W-1:0] hdr_char(input logic [2:0] pos);
      logic [DATA_W-1:0] c;
      case (pos)
         3'd0:    c = CHAR_DOLLAR;
         3'd1:    c = 8'h47;   // G
         3'd2:    c = 8'h50;   // P
         3'd3:    c = 8'h52;   // R
         3'd4:    c = 8'h4d;   // M
         3'd5:    c = 8'h43;   // C
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

/* src/nrsf_if.sv */
// ----------------------------------------------------------------------------
// nrsf interfaces
// Valid/ready channels for received bytes, sentence bytes and register writes.
// ----------------------------------------------------------------------------
interface nrsf_req_if import nrsf_pkg::*; ;
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data_byte;
   logic              block_start;
   modport source (output valid, output data_byte, output block_start, input ready);
   modport sink   (input valid, input data_byte, input block_start, output ready);
endinterface

interface nrsf_rsp_if import nrsf_pkg::*; ;
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] sentence_byte;
   logic              last_byte;
   modport source (output valid, output sentence_byte, output last_byte, input ready);
   modport sink   (input valid, input sentence_byte, input last_byte, output ready);
endinterface

interface nrsf_csr_if import nrsf_pkg::*; ;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] wdata;
   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

/* src/nrsf_cell.sv */
// ----------------------------------------------------------------------------
// nrsf_cell
// One byte of the capture row: loads when addressed, shifts toward the output.
// ----------------------------------------------------------------------------
module nrsf_cell import nrsf_pkg::*; #(
   parameter int INDEX = 0
) (
   input  logic              clock,
   input  cap_wr_type        wr,
   input  logic              shift,
   input  logic [DATA_W-1:0] nbr_data,
   output logic [DATA_W-1:0] data
);

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (shift) begin
         data_in = nbr_data;
      end else if (wr.we && (wr.addr == ADDR_W'(INDEX))) begin
         data_in = wr.data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

/* src/nrsf_match.sv */
// ----------------------------------------------------------------------------
// nrsf_match
// Header search, comma counting and validity check; steers capture writes.
// ----------------------------------------------------------------------------
module nrsf_match import nrsf_pkg::*; #(
   parameter int LEN_W = 7
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [DATA_W-1:0] data_byte,
   input  logic              block_start,
   input  logic [LEN_W-1:0]  eff_len,
   input  logic [5:0]        window,
   output cap_wr_type        wr,
   output logic              emit
);

   localparam int CW = (LEN_W > OFF_W + 1) ? LEN_W : OFF_W + 1;

   logic [2:0]       hpos_ff, hpos_in;
   logic             cand_ff, cand_in;
   logic [1:0]       comma_ff, comma_in;
   logic [OFF_W-1:0] off_ff, off_in;
   logic             valid_ff, valid_in;
   logic             found_ff, found_in;

   logic             fib, cand, vld, go, vv;
   logic [1:0]       cc;
   logic [OFF_W-1:0] off;
   logic [2:0]       p, p1;
   logic [CW-1:0]    off_x, len_x;

   always_comb begin
      hpos_in  = hpos_ff;
      cand_in  = cand_ff;
      comma_in = comma_ff;
      off_in   = off_ff;
      valid_in = valid_ff;
      found_in = found_ff;
      wr       = '0;
      emit     = 1'b0;
      fib      = found_ff & ~block_start;
      cand     = cand_ff & ~block_start;
      vld      = valid_ff & ~block_start;
      cc       = block_start ? 2'd0 : comma_ff;
      off      = block_start ? '0 : off_ff;
      p        = block_start ? 3'd0 : hpos_ff;
      p1       = p + 3'd1;
      go       = 1'b0;
      vv       = vld;
      off_x    = CW'(off);
      len_x    = CW'(eff_len);
      if (accept) begin
         if (block_start) begin
            found_in = 1'b0;
            cand_in  = 1'b0;
            valid_in = 1'b0;
            comma_in = 2'd0;
            off_in   = '0;
            hpos_in  = 3'd0;
         end
         if (!fib) begin
            if (!cand) begin
               if ((p < 3'(HDR_LEN)) && (data_byte == hdr_char(p))) begin
                  wr = '{we: 1'b1, addr: ADDR_W'(p), data: data_byte};
                  if (p1 == 3'(HDR_LEN)) begin
                     cand_in  = 1'b1;
                     valid_in = 1'b0;
                     comma_in = 2'd0;
                     off_in   = OFF_W'(HDR_LEN);
                     hpos_in  = 3'd0;
                  end else begin
                     hpos_in = p1;
                  end
               end else if (data_byte == CHAR_DOLLAR) begin
                  wr      = '{we: 1'b1, addr: '0, data: data_byte};
                  hpos_in = 3'd1;
               end else begin
                  hpos_in = 3'd0;
               end
            end else begin
               go = 1'b1;
               if (!vld) begin
                  if (data_byte == CHAR_DOLLAR) begin
                     // restart the header match on the new dollar
                     go       = 1'b0;
                     cand_in  = 1'b0;
                     valid_in = 1'b0;
                     comma_in = 2'd0;
                     off_in   = '0;
                     wr       = '{we: 1'b1, addr: '0, data: data_byte};
                     hpos_in  = 3'd1;
                  end else if (cc >= 2'd2) begin
                     if (data_byte != CHAR_A) begin
                        go = 1'b0;
                     end else begin
                        vv       = 1'b1;
                        valid_in = 1'b1;
                     end
                  end else if (off >= OFF_W'(window)) begin
                     go = 1'b0;
                  end else if (data_byte == CHAR_COMMA) begin
                     comma_in = cc + 2'd1;
                  end
                  if (!go && (data_byte != CHAR_DOLLAR)) begin
                     cand_in  = 1'b0;
                     valid_in = 1'b0;
                     comma_in = 2'd0;
                     off_in   = '0;
                     hpos_in  = 3'd0;
                  end
               end
               if (go) begin
                  if (off_x < len_x) begin
                     wr = '{we: 1'b1, addr: ADDR_W'(off), data: data_byte};
                  end
                  off_in = (off < OFF_MAX) ? off + OFF_W'(1) : OFF_MAX;
                  if (vv && ((off_x + CW'(1)) >= len_x)) begin
                     emit     = 1'b1;
                     found_in = 1'b1;
                     cand_in  = 1'b0;
                     valid_in = 1'b0;
                     comma_in = 2'd0;
                     off_in   = '0;
                     hpos_in  = 3'd0;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hpos_ff  <= 3'd0;
         cand_ff  <= 1'b0;
         comma_ff <= 2'd0;
         off_ff   <= '0;
         valid_ff <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         hpos_ff  <= hpos_in;
         cand_ff  <= cand_in;
         comma_ff <= comma_in;
         off_ff   <= off_in;
         valid_ff <= valid_in;
         found_ff <= found_in;
      end
   end

   a_hpos_range: assert property (@(posedge clock) disable iff (reset)
      hpos_ff < 3'(HDR_LEN))
      else $error("header position out of range");
   a_valid_needs_cand: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> cand_ff)
      else $error("valid sentence without candidate");
   a_emit_sets_found: assert property (@(posedge clock) disable iff (reset)
      emit |=> (found_ff && !cand_ff))
      else $error("emission did not close the block");

endmodule

/* src/nmea_rmc_sentence_filter.sv */
// ----------------------------------------------------------------------------
// nmea_rmc_sentence_filter
// Extracts the first valid RMC sentence of each reception block.
// ----------------------------------------------------------------------------
// Received bytes are taken one per cycle while no sentence is being drained.
// When a byte completes the capture of a valid sentence, the block stops
// taking input and shifts the captured bytes out of its row of MAX_CAPTURE
// byte cells, one per rsp transfer, so that run takes the effective capture
// length (1 to MAX_CAPTURE) in transfers. Register writes are always taken at once.
module nmea_rmc_sentence_filter import nrsf_pkg::*; #(
   parameter int MAX_CAPTURE = 64
) (
   input  logic       clock,
   input  logic       reset,
   nrsf_req_if.sink   req_chan,
   nrsf_rsp_if.source rsp_chan,
   nrsf_csr_if.sink   csr_chan
);

   localparam int LEN_W = $clog2(MAX_CAPTURE + 1);
   localparam int CMP_W = (LEN_W > 7) ? LEN_W : 7;

   logic [6:0]       cap_len_ff, cap_len_in;
   logic [5:0]       window_ff, window_in;
   logic [LEN_W-1:0] remain_ff, remain_in;
   logic [LEN_W-1:0] eff_len;
   logic             accept, emit, shift;
   cap_wr_type       wr;
   logic [DATA_W-1:0] cell_data [MAX_CAPTURE];

   always_comb begin
      if (cap_len_ff == 7'd0) begin
         eff_len = LEN_W'(1);
      end else if (CMP_W'(cap_len_ff) > CMP_W'(MAX_CAPTURE)) begin
         eff_len = LEN_W'(MAX_CAPTURE);
      end else begin
         eff_len = LEN_W'(cap_len_ff);
      end
   end

   assign csr_chan.ready = 1'b1;

   always_comb begin
      cap_len_in = cap_len_ff;
      window_in  = window_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            REG_CAPTURE_LENGTH:  cap_len_in = csr_chan.wdata;
            REG_VALIDITY_WINDOW: window_in  = csr_chan.wdata[5:0];
            default:             cap_len_in = cap_len_ff;
         endcase
      end
   end

   assign req_chan.ready     = (remain_ff == '0);
   assign accept             = req_chan.valid & req_chan.ready;
   assign rsp_chan.valid     = (remain_ff != '0);
   assign rsp_chan.sentence_byte = cell_data[0];
   assign rsp_chan.last_byte = (remain_ff == LEN_W'(1));
   assign shift              = rsp_chan.valid & rsp_chan.ready;

   always_comb begin
      remain_in = remain_ff;
      if (emit) begin
         remain_in = eff_len;
      end else if (shift) begin
         remain_in = remain_ff - LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_len_ff <= CAPTURE_LENGTH_RST;
         window_ff  <= VALIDITY_WINDOW_RST;
         remain_ff  <= '0;
      end else begin
         cap_len_ff <= cap_len_in;
         window_ff  <= window_in;
         remain_ff  <= remain_in;
      end
   end

   nrsf_match #(.LEN_W(LEN_W)) u_match (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .data_byte   (req_chan.data_byte),
      .block_start (req_chan.block_start),
      .eff_len     (eff_len),
      .window      (window_ff),
      .wr          (wr),
      .emit        (emit)
   );

   // cell 0 faces the output; each drain transfer moves the row down by one
   for (genvar i = 0; i < MAX_CAPTURE; i++) begin : g_cell
      logic [DATA_W-1:0] nbr;
      if (i == MAX_CAPTURE - 1) begin : g_end
         assign nbr = '0;
      end else begin : g_mid
         assign nbr = cell_data[i + 1];
      end
      nrsf_cell #(.INDEX(i)) u_cell (
         .clock    (clock),
         .wr       (wr),
         .shift    (shift),
         .nbr_data (nbr),
         .data     (cell_data[i])
      );
   end

   a_remain_bound: assert property (@(posedge clock) disable iff (reset)
      remain_ff <= LEN_W'(MAX_CAPTURE))
      else $error("drain count above capture size");
   a_emit_starts_run: assert property (@(posedge clock) disable iff (reset)
      emit |=> (rsp_chan.valid && (remain_ff == $past(eff_len))))
      else $error("run did not start with full length");
   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (shift && rsp_chan.last_byte) |=> !rsp_chan.valid)
      else $error("output still valid after last byte");
   a_no_write_in_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !wr.we)
      else $error("capture write during drain");

endmodule
